>>> rtl/flc_pkg.sv
`default_nettype none

package flc_pkg;

  // Control that travels with each request down the pipeline
  typedef struct packed {
    logic valid;
    logic func;
    logic nonpos;
  } ctl_t;

  // Function select codes
  localparam logic FUNC_DB = 1'b0;
  localparam logic FUNC_LN = 1'b1;

  // 1/sqrt(2) in Q2.30
  localparam logic signed [31:0] K_INV_SQRT2 = 32'sd759250112;

  // Minimax coefficients for log10 in Q6.26
  localparam logic signed [31:0] K_A5 = 32'sd75959200;
  localparam logic signed [31:0] K_A4 = -32'sd285795040;
  localparam logic signed [31:0] K_A3 = 32'sd457435200;
  localparam logic signed [31:0] K_A2 = -32'sd410610304;
  localparam logic signed [31:0] K_A1 = 32'sd244982704;
  localparam logic signed [31:0] K_A0 = -32'sd81731488;

  // log10(2) in Q6.26, ln(10) in Q3.29, dB scale in Q0
  localparam logic signed [31:0] K_LOG10_2 = 32'sd20201782;
  localparam logic signed [31:0] K_LN10    = 32'sd1236190976;
  localparam logic signed [31:0] K_DB_SCALE = 32'sd20;

  // Floor values for a non-positive input
  localparam logic signed [31:0] K_FLOOR_DB = -32'sd2097152000;
  localparam logic signed [31:0] K_FLOOR_LN = -32'sd2013265920;

  // Product shift amounts (qa + qb - qy - 1)
  localparam int unsigned SH_Q30  = 29;
  localparam int unsigned SH_EXP  = 0;
  localparam int unsigned SH_LN   = 28;
  localparam int unsigned SH_DB   = 4;

  // Rounded 32x32 product: (a*b + 2^sh) >>> (sh+1), low 32 bits kept
  function automatic logic signed [31:0] rmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b,
                                              input int unsigned sh);
    logic signed [63:0] prod;
    logic signed [63:0] sum;
    prod = a * b;
    sum  = prod + (64'sd1 <<< sh);
    sum  = sum >>> (sh + 1);
    return sum[31:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/flc_norm.sv
`default_nettype none

module flc_norm (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               func,
  input  wire logic signed [31:0] lin_value,
  output flc_pkg::ctl_t           ctl,
  output logic signed [31:0]      mant,
  output logic signed [6:0]       exp2
);

  logic [4:0]         msb_pos;
  logic [32:0]        mant_round;
  logic signed [31:0] mant_norm;
  logic signed [6:0]  exp_diff;
  logic signed [6:0]  exp_norm;

  flc_pkg::ctl_t      ctl1;
  logic signed [31:0] mant1;
  logic signed [6:0]  exp1;

  logic               fold;
  logic signed [31:0] mant_scaled;

  // Find leading one: position + 1, zero when no bit below the sign is set
  always_comb begin
    msb_pos = '0;
    for (int i = 0; i < 31; i++) begin
      if (lin_value[i]) begin
        msb_pos = 5'(i + 1);
      end
    end
  end

  // Normalize to a Q2.30 mantissa; round when bit 30 is set
  always_comb begin
    mant_round = {1'b0, lin_value} + 33'd1;
    if (lin_value[30]) begin
      mant_norm = mant_round[32:1];
    end else begin
      mant_norm = lin_value << (5'd30 - msb_pos);
    end
    exp_diff = $signed({2'b00, msb_pos}) - 7'sd26;
    exp_norm = {exp_diff[5:0], 1'b0};
  end

  // Stage 1: hold normalized mantissa and exponent in half octaves
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.valid <= 1'b0;
    end else begin
      ctl1.valid <= in_valid;
    end
    ctl1.func   <= func;
    ctl1.nonpos <= lin_value[31] | (lin_value == 32'sd0);
    mant1       <= mant_norm;
    exp1        <= exp_norm;
  end

  // Fold the upper half octave down by 1/sqrt(2)
  always_comb begin
    fold        = mant1 > flc_pkg::K_INV_SQRT2;
    mant_scaled = flc_pkg::rmul(mant1, flc_pkg::K_INV_SQRT2, flc_pkg::SH_Q30);
  end

  // Stage 2: hold folded mantissa
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= ctl1.valid;
    end
    ctl.func   <= ctl1.func;
    ctl.nonpos <= ctl1.nonpos;
    mant       <= fold ? mant_scaled : mant1;
    exp2       <= exp1 + {6'd0, fold};
  end

endmodule

`default_nettype wire

>>> rtl/flc_poly.sv
`default_nettype none

module flc_poly (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire flc_pkg::ctl_t      ctl_in,
  input  wire logic signed [31:0] mant,
  input  wire logic signed [6:0]  exp2,
  output flc_pkg::ctl_t           ctl_out,
  output logic signed [31:0]      log10_val
);

  flc_pkg::ctl_t      ctl3;
  logic signed [31:0] x2_3;
  logic signed [31:0] t5_3;
  logic signed [31:0] t3_3;
  logic signed [31:0] t1_3;
  logic signed [31:0] el_3;

  flc_pkg::ctl_t      ctl4;
  logic signed [31:0] x2_4;
  logic signed [31:0] x4_4;
  logic signed [31:0] u5_4;
  logic signed [31:0] u3_4;
  logic signed [31:0] base_4;

  flc_pkg::ctl_t      ctl5;
  logic signed [31:0] p5_5;
  logic signed [31:0] p3_5;
  logic signed [31:0] base_5;

  logic signed [31:0] exp_wide;

  assign exp_wide = {{25{exp2[6]}}, exp2};

  // Stage 3: square, odd terms and exponent contribution
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl3.valid <= 1'b0;
    end else begin
      ctl3.valid <= ctl_in.valid;
    end
    ctl3.func   <= ctl_in.func;
    ctl3.nonpos <= ctl_in.nonpos;
    x2_3 <= flc_pkg::rmul(mant, mant, flc_pkg::SH_Q30);
    t5_3 <= flc_pkg::rmul(flc_pkg::K_A5, mant, flc_pkg::SH_Q30);
    t3_3 <= flc_pkg::rmul(flc_pkg::K_A3, mant, flc_pkg::SH_Q30);
    t1_3 <= flc_pkg::rmul(flc_pkg::K_A1, mant, flc_pkg::SH_Q30);
    el_3 <= flc_pkg::rmul(exp_wide, flc_pkg::K_LOG10_2, flc_pkg::SH_EXP);
  end

  // Stage 4: fourth power and coefficient sums
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl4.valid <= 1'b0;
    end else begin
      ctl4.valid <= ctl3.valid;
    end
    ctl4.func   <= ctl3.func;
    ctl4.nonpos <= ctl3.nonpos;
    x2_4   <= x2_3;
    x4_4   <= flc_pkg::rmul(x2_3, x2_3, flc_pkg::SH_Q30);
    u5_4   <= t5_3 + flc_pkg::K_A4;
    u3_4   <= t3_3 + flc_pkg::K_A2;
    base_4 <= t1_3 + el_3;
  end

  // Stage 5: even-power products
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl5.valid <= 1'b0;
    end else begin
      ctl5.valid <= ctl4.valid;
    end
    ctl5.func   <= ctl4.func;
    ctl5.nonpos <= ctl4.nonpos;
    p5_5   <= flc_pkg::rmul(u5_4, x4_4, flc_pkg::SH_Q30);
    p3_5   <= flc_pkg::rmul(u3_4, x2_4, flc_pkg::SH_Q30);
    base_5 <= base_4 + flc_pkg::K_A0;
  end

  // Stage 6: accumulate log10 in Q6.26
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl5.valid;
    end
    ctl_out.func   <= ctl5.func;
    ctl_out.nonpos <= ctl5.nonpos;
    log10_val      <= p5_5 + p3_5 + base_5;
  end

endmodule

`default_nettype wire

>>> rtl/fixed_log_and_decibel_unit_core.sv
// Fixed-point log unit: takes a positive Q6.26 linear value and returns
// 20*log10 in Q11.21 (func 0) or ln in Q6.26 (func 1); a zero or negative
// input gives -1000 dB or -30 with nonpositive set. The unit is a seven-stage
// pipeline that takes a new request every cycle: busy is always low, and each
// result appears on result/nonpositive with done high for one cycle. The
// pipeline is built around the chain of dependent rounded multiplies
// (fold, square, fourth power, polynomial terms, final scale). There is no
// backpressure: the receiver must take every result.
`default_nettype none

module fixed_log_and_decibel_unit_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               func,
  input  wire logic signed [31:0] lin_value,
  output logic                    done,
  output logic signed [31:0]      result,
  output logic                    nonpositive
);

  flc_pkg::ctl_t      norm_ctl;
  logic signed [31:0] norm_mant;
  logic signed [6:0]  norm_exp2;

  flc_pkg::ctl_t      poly_ctl;
  logic signed [31:0] poly_log10;

  logic signed [31:0] scaled;

  // Accept a request every cycle
  assign busy = 1'b0;

  flc_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start),
    .func      (func),
    .lin_value (lin_value),
    .ctl       (norm_ctl),
    .mant      (norm_mant),
    .exp2      (norm_exp2)
  );

  flc_poly u_poly (
    .clk       (clk),
    .rst       (rst),
    .ctl_in    (norm_ctl),
    .mant      (norm_mant),
    .exp2      (norm_exp2),
    .ctl_out   (poly_ctl),
    .log10_val (poly_log10)
  );

  // Scale log10 to the selected output format, or pick the floor
  always_comb begin
    unique case (poly_ctl.func)
      flc_pkg::FUNC_LN: begin
        if (poly_ctl.nonpos) begin
          scaled = flc_pkg::K_FLOOR_LN;
        end else begin
          scaled = flc_pkg::rmul(flc_pkg::K_LN10, poly_log10, flc_pkg::SH_LN);
        end
      end
      default: begin
        if (poly_ctl.nonpos) begin
          scaled = flc_pkg::K_FLOOR_DB;
        end else begin
          scaled = flc_pkg::rmul(flc_pkg::K_DB_SCALE, poly_log10, flc_pkg::SH_DB);
        end
      end
    endcase
  end

  // Stage 7: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= poly_ctl.valid;
    end
    result      <= scaled;
    nonpositive <= poly_ctl.nonpos;
  end

endmodule

`default_nettype wire
